@@ hdl/cds_pkg.sv @@
`timescale 1ns / 1ps
package cds_pkg;

	localparam int MAX_WINDOW       = 7;
	localparam int MAX_IN_FEATURES  = 16;
	localparam int MAX_OUT_FEATURES = 16;
	localparam int MAX_RESULTS      = 64;
	localparam int W_DEPTH          = MAX_WINDOW * MAX_IN_FEATURES * MAX_OUT_FEATURES;
	localparam int WIN_DEPTH        = MAX_WINDOW * MAX_IN_FEATURES;

	// fixed field widths
	localparam int OP_W       = 2;
	localparam int IDX_W      = 11;
	localparam int VAL_W      = 16;
	localparam int FEAT_W     = 4;
	localparam int POS_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int ACC_W      = 41;

	// derived widths
	localparam int FP_W  = (MAX_IN_FEATURES > 1) ? $clog2(MAX_IN_FEATURES) : 1;
	localparam int RL_W  = $clog2(MAX_IN_FEATURES + 1);
	localparam int O_W   = (MAX_OUT_FEATURES > 1) ? $clog2(MAX_OUT_FEATURES) : 1;
	localparam int OC_W  = $clog2(MAX_OUT_FEATURES + 1);
	localparam int SL_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int T_W   = SL_W;
	localparam int WC_W  = $clog2(MAX_WINDOW + 1);
	localparam int WA_W  = $clog2(W_DEPTH);
	localparam int XA_W  = $clog2(WIN_DEPTH);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IN_FEATURES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_FEATURES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE  = 2'd3;

	typedef struct packed {
		logic take;
		logic o_init;
		logic issue;
		logic emit;
		logic next_o;
		logic next_pos;
		logic finish;
	} cds_cmd_t;

	typedef struct packed {
		logic row_done;
		logic pos_more;
		logic issue_last;
		logic pipe_empty;
		logic out_free;
		logic more_o;
	} cds_sts_t;

endpackage

@@ hdl/cds_if.sv @@
`timescale 1ns / 1ps
interface cds_in_if;
	logic                               valid;
	logic                               ready;
	logic [cds_pkg::OP_W-1:0]           op;
	logic [cds_pkg::IDX_W-1:0]          load_index;
	logic signed [cds_pkg::VAL_W-1:0]   value;
	logic                               end_of_sequence;
	modport source (output valid, op, load_index, value, end_of_sequence, input ready);
	modport sink (input valid, op, load_index, value, end_of_sequence, output ready);
endinterface

interface cds_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [cds_pkg::VAL_W-1:0]   result;
	logic [cds_pkg::FEAT_W-1:0]         out_feature;
	logic                               last_of_run;
	modport source (output valid, result, out_feature, last_of_run, input ready);
	modport sink (input valid, result, out_feature, last_of_run, output ready);
endinterface

interface cds_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cds_pkg::CFG_IDX_W-1:0]      index;
	logic [cds_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/conv1d_same_padding.sv @@
`timescale 1ns / 1ps
// Same-padded 1-D convolution, Q1.15 in and out. Items on the samples
// channel either load a weight (op 0, address (tap*in+f)*out+o), load a bias
// (op 1) or deliver one sample element (op 2); samples arrive row-major,
// in_features elements per position, end_of_sequence on the last one. Loads
// and elements that do not finish a row are taken without leaving idle. An
// item that finishes a row emits out_features results per computable
// position (one position normally, up to the right half-window more on end
// of sequence, capped at 64 results); last_of_run flags the final result.
// One shared MAC walks window*in_features products per result, 7*16 MACs at
// full size, through the single multiplier and its weight RAM read port.
// Config writes (index 0..3) are accepted any cycle but belong to idle
// periods.
module conv1d_same_padding (
	input  logic       clk,
	input  logic       arst_n,
	cds_in_if.sink     samples,
	cds_out_if.source  results,
	cds_cfg_if.sink    cfg
);
	cds_pkg::cds_cmd_t cmd;
	cds_pkg::cds_sts_t sts;

	// config is always taken
	assign cfg.ready = 1'b1;

	// FSM: intake, per-output-feature MAC sweep, drain, write, flush bookkeeping
	cds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(samples.valid), .in_ready(samples.ready),
		.sts(sts), .cmd(cmd)
	);

	// datapath: counters, window/weight RAMs, MAC pipe, output register
	cds_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(samples.op), .in_idx(samples.load_index),
		.in_value(samples.value), .in_eos(samples.end_of_sequence),
		.cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
		.out_valid(results.valid), .out_ready(results.ready),
		.out_result(results.result), .out_feature(results.out_feature),
		.out_last(results.last_of_run)
	);
endmodule

@@ hdl/cds_ram.sv @@
`timescale 1ns / 1ps
module cds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/cds_ctrl.sv @@
`timescale 1ns / 1ps
module cds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cds_pkg::cds_sts_t sts,
	output cds_pkg::cds_cmd_t cmd
);
	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_DRAIN, S_WRITE, S_FINISH} state_t;
	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.row_done) state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.pos_more) begin
					cmd.o_init = 1'b1;
					state_d    = S_ISSUE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.issue_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (sts.pipe_empty) state_d = S_WRITE;
			end
			S_WRITE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.more_o) begin
						cmd.next_o = 1'b1;
						state_d    = S_ISSUE;
					end else begin
						cmd.next_pos = 1'b1;
						state_d      = S_CHECK;
					end
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ hdl/cds_dp.sv @@
`timescale 1ns / 1ps
module cds_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cds_pkg::cds_cmd_t                  cmd,
	output cds_pkg::cds_sts_t                  sts,
	input  logic [cds_pkg::OP_W-1:0]           in_op,
	input  logic [cds_pkg::IDX_W-1:0]          in_idx,
	input  logic signed [cds_pkg::VAL_W-1:0]   in_value,
	input  logic                               in_eos,
	input  logic                               cfg_we,
	input  logic [cds_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [cds_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [cds_pkg::VAL_W-1:0]   out_result,
	output logic [cds_pkg::FEAT_W-1:0]         out_feature,
	output logic                               out_last
);
	localparam int POS_X = cds_pkg::POS_W + 2;

	// configuration
	logic [4:0] in_feat_q, out_feat_q;
	logic [2:0] win_cfg_q;
	logic       bias_en_q;

	logic [cds_pkg::RL_W-1:0] nin;
	logic [cds_pkg::OC_W-1:0] nout;
	logic [cds_pkg::WC_W-1:0] win, left, right;

	always_comb begin
		if (in_feat_q == 5'd0) nin = cds_pkg::RL_W'(1);
		else if (32'(in_feat_q) > cds_pkg::MAX_IN_FEATURES)
			nin = cds_pkg::RL_W'(cds_pkg::MAX_IN_FEATURES);
		else nin = cds_pkg::RL_W'(in_feat_q);
		if (out_feat_q == 5'd0) nout = cds_pkg::OC_W'(1);
		else if (32'(out_feat_q) > cds_pkg::MAX_OUT_FEATURES)
			nout = cds_pkg::OC_W'(cds_pkg::MAX_OUT_FEATURES);
		else nout = cds_pkg::OC_W'(out_feat_q);
		if (win_cfg_q == 3'd0) win = cds_pkg::WC_W'(1);
		else if (32'(win_cfg_q) > cds_pkg::MAX_WINDOW)
			win = cds_pkg::WC_W'(cds_pkg::MAX_WINDOW);
		else win = cds_pkg::WC_W'(win_cfg_q);
		left  = (win - cds_pkg::WC_W'(1)) >> 1;
		right = win - cds_pkg::WC_W'(1) - left;
	end

	// sequence state
	logic [cds_pkg::FP_W-1:0]  fp_q;
	logic [cds_pkg::POS_W-1:0] rows_q, next_q, p_q, end_q;
	logic [cds_pkg::SL_W-1:0]  newest_q;
	logic                      eos_q;
	logic [cds_pkg::RL_W-1:0]  row_len_q [cds_pkg::MAX_WINDOW];
	logic signed [cds_pkg::VAL_W-1:0] bias_q [cds_pkg::MAX_OUT_FEATURES];
	logic [cds_pkg::CNT_W-1:0] count_q;

	// item intake
	logic                      is_sample, row_done, e1;
	logic [cds_pkg::SL_W-1:0]  newest_new;
	logic [cds_pkg::POS_W-1:0] rows_new, p_start, end_new, next_new, rows_m_right;

	always_comb begin
		is_sample = (in_op == cds_pkg::OP_SAMPLE);
		if (fp_q != '0) newest_new = newest_q;
		else if (rows_q == '0) newest_new = '0;
		else if (32'(newest_q) == cds_pkg::MAX_WINDOW - 1) newest_new = '0;
		else newest_new = newest_q + cds_pkg::SL_W'(1);
		row_done = is_sample &&
			((cds_pkg::RL_W'(fp_q) + cds_pkg::RL_W'(1) >= nin) || in_eos);
		rows_new     = rows_q + cds_pkg::POS_W'(1);
		rows_m_right = rows_q - cds_pkg::POS_W'(right);
		e1       = (rows_new != '0) && (rows_q >= cds_pkg::POS_W'(right));
		p_start  = e1 ? rows_m_right : next_q;
		next_new = e1 ? rows_m_right + cds_pkg::POS_W'(1) : next_q;
		if (in_eos) end_new = rows_new;
		else end_new = e1 ? next_new : p_start;
	end

	// MAC sequencing
	logic [cds_pkg::O_W-1:0]  o_q;
	logic [cds_pkg::T_W-1:0]  t_q;
	logic [cds_pkg::FP_W-1:0] f_q;
	logic [cds_pkg::WA_W-1:0] waddr_q;
	logic signed [POS_X-1:0]  q_pos, d_pos, newest_s;
	logic                     tap_ok, feat_ok;
	logic [cds_pkg::SL_W:0]   slot_w;
	logic [cds_pkg::SL_W-1:0] slot, dsl;

	always_comb begin
		newest_s = $signed({2'b00, rows_q}) - POS_X'(1);
		q_pos    = $signed({2'b00, p_q}) - $signed(POS_X'(left)) + $signed(POS_X'(t_q));
		d_pos    = newest_s - q_pos;
		tap_ok   = (q_pos >= 0) && (d_pos >= 0) && (d_pos < POS_X'(cds_pkg::MAX_WINDOW));
		dsl      = d_pos[cds_pkg::SL_W-1:0];
		if (newest_q >= dsl) slot_w = {1'b0, newest_q} - {1'b0, dsl};
		else slot_w = {1'b0, newest_q} + (cds_pkg::SL_W+1)'(cds_pkg::MAX_WINDOW) - {1'b0, dsl};
		slot    = tap_ok ? slot_w[cds_pkg::SL_W-1:0] : '0;
		feat_ok = cds_pkg::RL_W'(f_q) < row_len_q[slot];
	end

	// memories
	logic                       x_we, w_we;
	logic [cds_pkg::XA_W-1:0]   x_waddr, x_raddr;
	logic [cds_pkg::VAL_W-1:0]  x_rdata, w_rdata;

	assign x_we    = cmd.take && is_sample;
	assign x_waddr = cds_pkg::XA_W'(newest_new) * cds_pkg::XA_W'(cds_pkg::MAX_IN_FEATURES)
		+ cds_pkg::XA_W'(fp_q);
	assign x_raddr = cds_pkg::XA_W'(slot) * cds_pkg::XA_W'(cds_pkg::MAX_IN_FEATURES)
		+ cds_pkg::XA_W'(f_q);
	assign w_we    = cmd.take && (in_op == cds_pkg::OP_WEIGHT) &&
		(32'(in_idx) < cds_pkg::W_DEPTH);

	cds_ram #(.WIDTH(cds_pkg::VAL_W), .DEPTH(cds_pkg::WIN_DEPTH)) u_window (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(in_value),
		.raddr(x_raddr), .rdata(x_rdata)
	);

	cds_ram #(.WIDTH(cds_pkg::VAL_W), .DEPTH(cds_pkg::W_DEPTH)) u_weight (
		.clk(clk), .we(w_we), .waddr(cds_pkg::WA_W'(in_idx)), .wdata(in_value),
		.raddr(waddr_q), .rdata(w_rdata)
	);

	// pipeline: s1 RAM data, s2 product, then accumulate
	logic                              pipe_s1, gate_s1, pipe_s2;
	logic signed [2*cds_pkg::VAL_W-1:0] prod_s2;
	logic signed [cds_pkg::ACC_W-1:0]  acc_q;

	// rounding and saturation
	logic signed [cds_pkg::ACC_W-1:0]  biased, shifted;
	logic signed [cds_pkg::VAL_W-1:0]  sat;
	logic                              last_now, f_wrap;

	always_comb begin
		biased = acc_q + cds_pkg::ACC_W'(32'sd16384);
		if (bias_en_q) biased = biased + ($signed(cds_pkg::ACC_W'(bias_q[o_q])) <<< 15);
		shifted = biased >>> 15;
		if (shifted > $signed(cds_pkg::ACC_W'(32767))) sat = 16'sh7fff;
		else if (shifted < -$signed(cds_pkg::ACC_W'(32768))) sat = -16'sh8000;
		else sat = shifted[cds_pkg::VAL_W-1:0];
		last_now = ((cds_pkg::OC_W'(o_q) == nout - cds_pkg::OC_W'(1)) &&
			!(({1'b0, p_q} + 17'd1) < {1'b0, end_q})) ||
			(32'(count_q) == cds_pkg::MAX_RESULTS - 1);
		f_wrap = (cds_pkg::RL_W'(f_q) == nin - cds_pkg::RL_W'(1));
	end

	always_comb begin
		sts.row_done   = row_done;
		sts.pos_more   = (p_q < end_q) && (32'(count_q) < cds_pkg::MAX_RESULTS);
		sts.issue_last = (cds_pkg::WC_W'(t_q) == win - cds_pkg::WC_W'(1)) && f_wrap;
		sts.pipe_empty = !pipe_s1 && !pipe_s2;
		sts.out_free   = !out_valid || out_ready;
		sts.more_o     = (cds_pkg::OC_W'(o_q) != nout - cds_pkg::OC_W'(1)) &&
			(32'(count_q) != cds_pkg::MAX_RESULTS - 1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_feat_q  <= 5'd1;
			out_feat_q <= 5'd1;
			win_cfg_q  <= 3'd3;
			bias_en_q  <= 1'b1;
			fp_q       <= '0;
			rows_q     <= '0;
			next_q     <= '0;
			newest_q   <= '0;
			eos_q      <= 1'b0;
			count_q    <= '0;
			pipe_s1    <= 1'b0;
			pipe_s2    <= 1'b0;
			out_valid  <= 1'b0;
			for (int i = 0; i < cds_pkg::MAX_WINDOW; i++) row_len_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					cds_pkg::REG_IN_FEATURES:  in_feat_q  <= cfg_data;
					cds_pkg::REG_OUT_FEATURES: out_feat_q <= cfg_data;
					cds_pkg::REG_WINDOW_SIZE:  win_cfg_q  <= cfg_data[2:0];
					cds_pkg::REG_BIAS_ENABLE:  bias_en_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take && is_sample) begin
				newest_q <= newest_new;
				row_len_q[newest_new] <= cds_pkg::RL_W'(fp_q) + cds_pkg::RL_W'(1);
				if (row_done) begin
					fp_q    <= '0;
					rows_q  <= rows_new;
					next_q  <= next_new;
					eos_q   <= in_eos;
					count_q <= '0;
				end else begin
					fp_q <= fp_q + cds_pkg::FP_W'(1);
				end
			end
			if (cmd.emit) count_q <= count_q + cds_pkg::CNT_W'(1);
			if (cmd.finish && eos_q) begin
				rows_q   <= '0;
				next_q   <= '0;
				newest_q <= '0;
			end
			pipe_s1 <= cmd.issue;
			pipe_s2 <= pipe_s1;
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take && (in_op == cds_pkg::OP_BIAS) &&
			(32'(in_idx) < cds_pkg::MAX_OUT_FEATURES)) begin
			bias_q[cds_pkg::O_W'(in_idx)] <= in_value;
		end
		if (cmd.take && row_done) begin
			p_q   <= p_start;
			end_q <= end_new;
		end
		if (cmd.next_pos) p_q <= p_q + cds_pkg::POS_W'(1);
		if (cmd.o_init || cmd.next_o) begin
			t_q     <= '0;
			f_q     <= '0;
			acc_q   <= '0;
			o_q     <= cmd.o_init ? '0 : o_q + cds_pkg::O_W'(1);
			waddr_q <= cmd.o_init ? '0 : cds_pkg::WA_W'(o_q) + cds_pkg::WA_W'(1);
		end else begin
			if (cmd.issue) begin
				waddr_q <= waddr_q + cds_pkg::WA_W'(nout);
				if (f_wrap) begin
					f_q <= '0;
					t_q <= t_q + cds_pkg::T_W'(1);
				end else begin
					f_q <= f_q + cds_pkg::FP_W'(1);
				end
			end
			if (pipe_s2) acc_q <= acc_q + cds_pkg::ACC_W'(prod_s2);
		end
		gate_s1 <= cmd.issue && tap_ok && feat_ok;
		// signed zero keeps the product a signed multiply
		prod_s2 <= gate_s1 ? $signed(x_rdata) * $signed(w_rdata)
			: (2*cds_pkg::VAL_W)'(0);
		if (cmd.emit) begin
			out_result  <= sat;
			out_feature <= cds_pkg::FEAT_W'(o_q);
			out_last    <= last_now;
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result written while output busy");
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!pipe_s1 && !pipe_s2))
		else $error("result written before MAC pipeline drained");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= cds_pkg::MAX_RESULTS)
		else $error("result count beyond cap");
`endif
endmodule
